/* hw/rtl/i2c_eeprom_transaction_sequencer_top_macros.svh */
// Assertion macros for the I2C memory-transfer sequencer.
// Taken in by the top level; no other dependencies.
`ifndef I2C_EEPROM_TRANSACTION_SEQUENCER_TOP_MACROS_SVH
`define I2C_EEPROM_TRANSACTION_SEQUENCER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define I2CS_ASSERT_SAME(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define I2CS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define I2CS_ASSERT_SAME(lbl, clk, rst_n, pre, post, msg)
`define I2CS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

/* hw/rtl/i2cs_pkg.sv */
// Shared types and codes for the I2C memory-transfer sequencer.
// No dependencies.
`timescale 1ns / 1ps

package i2cs_pkg;

  // input word function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DONE  = 1'b1;

  // master command codes
  localparam logic [2:0] CMD_NONE       = 3'd0;
  localparam logic [2:0] CMD_SEND_START = 3'd1;
  localparam logic [2:0] CMD_SEND_CONT  = 3'd2;
  localparam logic [2:0] CMD_SEND_FIN   = 3'd3;
  localparam logic [2:0] CMD_RX_SINGLE  = 3'd4;
  localparam logic [2:0] CMD_RX_START   = 3'd5;
  localparam logic [2:0] CMD_RX_CONT    = 3'd6;
  localparam logic [2:0] CMD_RX_FIN     = 3'd7;

  // width of the address byte counters (address length is at most 4)
  localparam int ADDR_CNT_W = 3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ADDR,
    PH_DATA,
    PH_FINISH
  } phase_t;

  typedef struct packed {
    logic        func;
    logic [6:0]  slave_addr;
    logic [3:0]  addr_len;
    logic [31:0] mem_addr;
    logic [15:0] xfer_size;
    logic        is_read;
    logic        bus_error;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  command;
    logic        addr_valid;
    logic        addr_rw;
    logic        put_valid;
    logic [7:0]  put_byte;
    logic        store_valid;
    logic [7:0]  store_byte;
    logic [15:0] store_index;
    logic [15:0] next_index;
    logic        finished;
    logic        failed;
  } out_word_t;

endpackage

/* hw/rtl/i2c_eeprom_transaction_sequencer_top.sv */
// Top level of the I2C memory-transfer sequencer.
// Depends on i2cs_pkg, i2cs_in_stage, i2cs_core and the macros header.
//
//   channel | direction | handshake          | word type
//   --------+-----------+--------------------+---------------------
//   in_     | input     | in_valid/in_stall  | i2cs_pkg::in_word_t
//   out_    | output    | out_valid/out_stall| i2cs_pkg::out_word_t
//
// An accepted word is held in the input register; the core's result for it is then
// captured in the result register, where it waits while out_stall is high.
// One word per clock, back to back, while out_stall is low; the core forms the
// result and updates the transfer state in the same cycle.
// Reset (rst_n low, synchronous) empties both stages and idles the sequencer.
// A stalled result holds; the input register takes one more word, then stalls.
`timescale 1ns / 1ps
`include "i2c_eeprom_transaction_sequencer_top_macros.svh"

module i2c_eeprom_transaction_sequencer_top #(
  parameter int COUNT_WIDTH    = 16,
  parameter int MAX_ADDR_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  i2cs_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cs_pkg::out_word_t out_word
);

  logic                held_valid;
  i2cs_pkg::in_word_t  held_word;
  logic                step;
  i2cs_pkg::out_word_t result;

  logic                out_valid_r, out_valid_nxt;
  i2cs_pkg::out_word_t out_word_r;

  // terms for the checks at the end
  logic                fail_seen;
  logic                fail_clean;
  logic                put_seen;
  logic                addr_seen;
  logic                addr_cmd_ok;

  // the held word moves on whenever the result register is free or drains
  assign step = held_valid && (!out_valid_r || !out_stall);

  i2cs_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .take       (step),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  i2cs_core #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .MAX_ADDR_BYTES (MAX_ADDR_BYTES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .word   (held_word),
    .result (result)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (step) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // checks
  assign fail_seen   = out_valid_r && out_word_r.failed;
  assign fail_clean  = out_word_r.finished && out_word_r.command == i2cs_pkg::CMD_NONE;
  assign put_seen    = out_valid_r && out_word_r.put_valid;
  assign addr_seen   = out_valid_r && out_word_r.addr_valid;
  assign addr_cmd_ok = out_word_r.command == i2cs_pkg::CMD_SEND_START ||
                       out_word_r.command == i2cs_pkg::CMD_RX_SINGLE ||
                       out_word_r.command == i2cs_pkg::CMD_RX_START;

  `I2CS_ASSERT_NEXT(a_step_fills_out, clk, rst_n, step, out_valid_r, "result lost after step")
  `I2CS_ASSERT_SAME(a_fail_ends, clk, rst_n, fail_seen, fail_clean, "failure without end")
  `I2CS_ASSERT_SAME(a_put_xor_store, clk, rst_n, put_seen, !out_word_r.store_valid, "put+store")
  `I2CS_ASSERT_SAME(a_addr_cmd, clk, rst_n, addr_seen, addr_cmd_ok, "address load on wrong command")

endmodule

/* hw/rtl/i2cs_in_stage.sv */
// Input register stage of the sequencer: holds one accepted word.
// Depends on i2cs_pkg.
`timescale 1ns / 1ps

module i2cs_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  i2cs_pkg::in_word_t in_word,
  input  logic             take,
  output logic             held_valid,
  output i2cs_pkg::in_word_t held_word
);

  logic               valid_r;
  logic               valid_nxt;
  i2cs_pkg::in_word_t word_r;
  logic               load;

  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= in_word;
    end
  end

  assign held_valid = valid_r;
  assign held_word  = word_r;

endmodule

/* hw/rtl/i2cs_core.sv */
// Transfer state machine: turns one input word into one result word.
// Depends on i2cs_pkg.
`timescale 1ns / 1ps

module i2cs_core #(
  parameter int COUNT_WIDTH    = 16,
  parameter int MAX_ADDR_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  i2cs_pkg::in_word_t  word,
  output i2cs_pkg::out_word_t result
);

  localparam int AW = 8 * MAX_ADDR_BYTES;
  localparam int CW = COUNT_WIDTH;
  localparam int AC = i2cs_pkg::ADDR_CNT_W;

  i2cs_pkg::phase_t phase_r, phase_nxt;
  logic [AW-1:0] addr_sh_r, addr_sh_nxt;
  logic [AC-1:0] addr_left_r, addr_left_nxt;
  logic [CW-1:0] data_pos_r, data_pos_nxt;
  logic [CW-1:0] byte_total_r, byte_total_nxt;
  logic          read_mode_r, read_mode_nxt;

  logic [AC-1:0] len_c;
  logic [31:0]   addr_aligned;
  logic [31:0]   size_ext;
  logic [CW-1:0] total_c;
  logic [CW-1:0] dp_inc;
  logic [31:0]   pos_ext;
  logic [31:0]   idx_ext;

  always_comb begin
    len_c = (word.addr_len > 4'(MAX_ADDR_BYTES)) ? AC'(MAX_ADDR_BYTES) : word.addr_len[AC-1:0];
    // left-justify the used address bytes so the first one sits on top
    addr_aligned = word.mem_addr << {(AC'(MAX_ADDR_BYTES) - len_c), 3'b000};
    size_ext = 32'(word.xfer_size);
    total_c = (|(size_ext >> CW)) ? {CW{1'b1}} : size_ext[CW-1:0];
    dp_inc = data_pos_r + CW'(1);
  end

  always_comb begin
    phase_nxt      = phase_r;
    addr_sh_nxt    = addr_sh_r;
    addr_left_nxt  = addr_left_r;
    data_pos_nxt   = data_pos_r;
    byte_total_nxt = byte_total_r;
    read_mode_nxt  = read_mode_r;
    result         = '0;
    idx_ext        = '0;

    priority if (word.func == i2cs_pkg::FUNC_START) begin
      if (word.addr_len == 4'd0 || word.xfer_size == 16'd0) begin
        phase_nxt       = i2cs_pkg::PH_IDLE;
        result.finished = 1'b1;
      end else begin
        read_mode_nxt     = word.is_read;
        byte_total_nxt    = total_c;
        addr_left_nxt     = len_c - AC'(1);
        addr_sh_nxt       = addr_aligned[AW-1:0] << 8;
        data_pos_nxt      = '0;
        phase_nxt         = i2cs_pkg::PH_ADDR;
        result.command    = i2cs_pkg::CMD_SEND_START;
        result.addr_valid = 1'b1;
        result.put_valid  = 1'b1;
        result.put_byte   = addr_aligned[AW-1 -: 8];
      end
    end else if (phase_r == i2cs_pkg::PH_IDLE) begin
      // stray done event: nothing to do
    end else if (word.bus_error) begin
      phase_nxt       = i2cs_pkg::PH_IDLE;
      result.finished = 1'b1;
      result.failed   = 1'b1;
    end else begin
      unique case (phase_r)
        i2cs_pkg::PH_ADDR, i2cs_pkg::PH_DATA: begin
          if (phase_r == i2cs_pkg::PH_ADDR && addr_left_r != '0) begin
            result.command   = i2cs_pkg::CMD_SEND_CONT;
            result.put_valid = 1'b1;
            result.put_byte  = addr_sh_r[AW-1 -: 8];
            addr_sh_nxt      = addr_sh_r << 8;
            addr_left_nxt    = addr_left_r - AC'(1);
          end else if (phase_r == i2cs_pkg::PH_ADDR && read_mode_r) begin
            // address done on a read: reload slave address with read bit
            result.addr_valid = 1'b1;
            result.addr_rw    = 1'b1;
            if (byte_total_r == CW'(1)) begin
              phase_nxt      = i2cs_pkg::PH_FINISH;
              result.command = i2cs_pkg::CMD_RX_SINGLE;
            end else begin
              phase_nxt      = i2cs_pkg::PH_DATA;
              result.command = i2cs_pkg::CMD_RX_START;
            end
          end else if (read_mode_r) begin
            data_pos_nxt       = dp_inc;
            result.store_valid = 1'b1;
            result.store_byte  = word.rx_byte;
            idx_ext            = 32'(data_pos_r);
            result.store_index = idx_ext[15:0];
            if (({1'b0, dp_inc} + (CW+1)'(1)) < {1'b0, byte_total_r}) begin
              phase_nxt      = i2cs_pkg::PH_DATA;
              result.command = i2cs_pkg::CMD_RX_CONT;
            end else begin
              phase_nxt      = i2cs_pkg::PH_FINISH;
              result.command = i2cs_pkg::CMD_RX_FIN;
            end
          end else begin
            // write data byte; address phase falls through to here
            data_pos_nxt     = dp_inc;
            result.put_valid = 1'b1;
            result.put_byte  = word.tx_byte;
            if (dp_inc < byte_total_r) begin
              phase_nxt      = i2cs_pkg::PH_DATA;
              result.command = i2cs_pkg::CMD_SEND_CONT;
            end else begin
              phase_nxt      = i2cs_pkg::PH_FINISH;
              result.command = i2cs_pkg::CMD_SEND_FIN;
            end
          end
        end
        i2cs_pkg::PH_FINISH: begin
          phase_nxt       = i2cs_pkg::PH_IDLE;
          result.finished = 1'b1;
          if (read_mode_r) begin
            result.store_valid = 1'b1;
            result.store_byte  = word.rx_byte;
            idx_ext            = 32'(data_pos_r);
            result.store_index = idx_ext[15:0];
          end
        end
        default: begin
        end
      endcase
    end

    pos_ext           = 32'(data_pos_nxt);
    result.next_index = pos_ext[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= i2cs_pkg::PH_IDLE;
      addr_left_r  <= '0;
      data_pos_r   <= '0;
      byte_total_r <= '0;
      read_mode_r  <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      addr_left_r  <= addr_left_nxt;
      data_pos_r   <= data_pos_nxt;
      byte_total_r <= byte_total_nxt;
      read_mode_r  <= read_mode_nxt;
    end
  end

  // address shift register: loaded on every start before it is read
  always_ff @(posedge clk) begin
    if (step) begin
      addr_sh_r <= addr_sh_nxt;
    end
  end

endmodule

/* sim/tb_i2c_eeprom_transaction_sequencer_top.sv */
// Testbench for the I2C memory-transfer sequencer: directed and random transfers,
// each result word checked against an in-bench model of the sequencer.
// Depends on i2cs_pkg and the i2c_eeprom_transaction_sequencer_top RTL.
`timescale 1ns / 1ps

module tb_i2c_eeprom_transaction_sequencer_top;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  i2cs_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_stall;
  i2cs_pkg::out_word_t out_word;

  i2c_eeprom_transaction_sequencer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Model of the sequencer state. Updated once per accepted input word, in
  // acceptance order, so it always reflects the transfer as the DUT sees it.
  // ---------------------------------------------------------------------------
  i2cs_pkg::phase_t seq_phase;
  logic [7:0]       seq_addr_bytes [4];
  int               seq_addr_count;
  int               seq_addr_pos;
  logic [15:0]      seq_data_pos;
  logic [15:0]      seq_total;
  logic             seq_read;
  logic [6:0]       seq_slave;

  i2cs_pkg::out_word_t expected_steps [$];  // predicted result words, oldest first
  int                  mismatches;
  int                  words_sent;
  bit                  gaps_on;             // random idling on both channels

  // Next master step for one input word; advances the model state.
  function automatic i2cs_pkg::out_word_t master_step(i2cs_pkg::in_word_t w);
    i2cs_pkg::out_word_t r;
    int                  len;
    logic [15:0]         idx;
    r = '0;
    if (w.func == i2cs_pkg::FUNC_START) begin
      if (w.addr_len == 4'd0 || w.xfer_size == 16'd0) begin
        // empty transfer: no command, straight back to idle
        seq_phase  = i2cs_pkg::PH_IDLE;
        r.finished = 1'b1;
      end else begin
        len = (w.addr_len > 4) ? 4 : int'(w.addr_len);  // long address clamps
        seq_slave      = w.slave_addr;
        seq_read       = w.is_read;
        seq_total      = w.xfer_size;
        seq_addr_count = len;
        for (int k = 0; k < len; k++)
          seq_addr_bytes[k] = 8'(w.mem_addr >> (8 * (len - 1 - k)));  // MSB first
        seq_data_pos = '0;
        seq_addr_pos = 1;
        seq_phase    = i2cs_pkg::PH_ADDR;
        r.command    = i2cs_pkg::CMD_SEND_START;
        r.addr_valid = 1'b1;
        r.put_valid  = 1'b1;
        r.put_byte   = seq_addr_bytes[0];
      end
    end else if (seq_phase == i2cs_pkg::PH_IDLE) begin
      // done while idle: ignored
    end else if (w.bus_error) begin
      seq_phase  = i2cs_pkg::PH_IDLE;
      r.finished = 1'b1;
      r.failed   = 1'b1;
    end else if (seq_phase == i2cs_pkg::PH_ADDR && seq_addr_pos < seq_addr_count) begin
      r.command   = i2cs_pkg::CMD_SEND_CONT;
      r.put_valid = 1'b1;
      r.put_byte  = seq_addr_bytes[seq_addr_pos];
      seq_addr_pos++;
    end else if (seq_phase == i2cs_pkg::PH_ADDR && seq_read) begin
      // address sent: reload slave address with the read bit
      r.addr_valid = 1'b1;
      r.addr_rw    = 1'b1;
      if (seq_total == 16'd1) begin
        seq_phase = i2cs_pkg::PH_FINISH;
        r.command = i2cs_pkg::CMD_RX_SINGLE;
      end else begin
        seq_phase = i2cs_pkg::PH_DATA;
        r.command = i2cs_pkg::CMD_RX_START;
      end
    end else if (seq_phase != i2cs_pkg::PH_FINISH) begin
      // data phase; a write falls in here straight from the address phase
      seq_phase = i2cs_pkg::PH_DATA;
      if (seq_read) begin
        idx          = seq_data_pos;
        seq_data_pos = seq_data_pos + 16'd1;
        if (int'(seq_data_pos) + 1 < int'(seq_total)) begin
          r.command = i2cs_pkg::CMD_RX_CONT;
        end else begin
          seq_phase = i2cs_pkg::PH_FINISH;
          r.command = i2cs_pkg::CMD_RX_FIN;
        end
        r.store_valid = 1'b1;
        r.store_byte  = w.rx_byte;
        r.store_index = idx;
      end else begin
        seq_data_pos = seq_data_pos + 16'd1;
        if (seq_data_pos < seq_total) begin
          r.command = i2cs_pkg::CMD_SEND_CONT;
        end else begin
          seq_phase = i2cs_pkg::PH_FINISH;
          r.command = i2cs_pkg::CMD_SEND_FIN;
        end
        r.put_valid = 1'b1;
        r.put_byte  = w.tx_byte;
      end
    end else begin
      // finish phase: last received byte lands at the current index
      seq_phase  = i2cs_pkg::PH_IDLE;
      r.finished = 1'b1;
      if (seq_read) begin
        r.store_valid = 1'b1;
        r.store_byte  = w.rx_byte;
        r.store_index = seq_data_pos;
      end
    end
    r.next_index = seq_data_pos;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver. Optional idle cycles before the word, then hold until
  // accepted. in_stall is read right after the edge, i.e. the value the DUT saw.
  // ---------------------------------------------------------------------------
  task automatic send_word(input i2cs_pkg::in_word_t w);
    while (gaps_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_steps.push_back(master_step(w));
    words_sent++;
  endtask

  // Sender holds off until every predicted result word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_steps.size() != 0) @(posedge clk);
  endtask

  function automatic i2cs_pkg::in_word_t random_word();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(i2cs_pkg::in_word_t)-1:0];
  endfunction

  function automatic i2cs_pkg::in_word_t done_word(input int err_pct);
    i2cs_pkg::in_word_t w;
    w           = random_word();
    w.func      = i2cs_pkg::FUNC_DONE;
    w.bus_error = ($urandom_range(99) < err_pct);
    return w;
  endfunction

  function automatic i2cs_pkg::in_word_t start_word(input logic [6:0] slave,
                                                    input logic [3:0] len,
                                                    input logic [31:0] maddr,
                                                    input logic [15:0] size,
                                                    input logic rd);
    i2cs_pkg::in_word_t w;
    w            = random_word();
    w.func       = i2cs_pkg::FUNC_START;
    w.slave_addr = slave;
    w.addr_len   = len;
    w.mem_addr   = maddr;
    w.xfer_size  = size;
    w.is_read    = rd;
    return w;
  endfunction

  // Mostly well-formed transfers of short length; some empty, clamped or huge.
  function automatic i2cs_pkg::in_word_t random_start();
    i2cs_pkg::in_word_t w;
    int                 pick;
    w      = random_word();
    w.func = i2cs_pkg::FUNC_START;
    pick   = $urandom_range(99);
    if (pick < 5)       w.addr_len = 4'd0;
    else if (pick < 12) w.addr_len = 4'($urandom_range(5, 15));
    else                w.addr_len = 4'($urandom_range(1, 4));
    pick = $urandom_range(99);
    if (pick < 5)       w.xfer_size = 16'd0;
    else if (pick < 15) w.xfer_size = 16'($urandom());
    else                w.xfer_size = 16'($urandom_range(1, 8));
    return w;
  endfunction

  // One transfer: start word, then done words until the model goes idle or
  // max_done is reached (what is left is aborted by the next start).
  task automatic run_transfer(input i2cs_pkg::in_word_t start_w, input int err_pct,
                              input int max_done);
    int n;
    n = 0;
    send_word(start_w);
    while (seq_phase != i2cs_pkg::PH_IDLE && n < max_done) begin
      send_word(done_word(err_pct));
      n++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, and compare every accepted word in order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 15);
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_step(input i2cs_pkg::out_word_t got);
    i2cs_pkg::out_word_t want;
    if (expected_steps.size() == 0) begin
      mismatches++;
      $display("%0t ns: result word with none expected, expected none actual %h",
               $time, got);
    end else begin
      want = expected_steps.pop_front();
      check_field("command",     want.command,     got.command);
      check_field("addr_valid",  want.addr_valid,  got.addr_valid);
      check_field("addr_rw",     want.addr_rw,     got.addr_rw);
      check_field("put_valid",   want.put_valid,   got.put_valid);
      check_field("put_byte",    want.put_byte,    got.put_byte);
      check_field("store_valid", want.store_valid, got.store_valid);
      check_field("store_byte",  want.store_byte,  got.store_byte);
      check_field("store_index", want.store_index, got.store_index);
      check_field("next_index",  want.next_index,  got.next_index);
      check_field("finished",    want.finished,    got.finished);
      check_field("failed",      want.failed,      got.failed);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_step(out_word);
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Done while idle is ignored; zero length or zero count finishes at once.
  task automatic test_idle_and_empty();
    i2cs_pkg::in_word_t w;
    w = done_word(0);
    w.bus_error = 1'b1;
    w.rx_byte   = 8'hFF;
    w.tx_byte   = 8'hFF;
    send_word(w);
    send_word(done_word(0));
    send_word(start_word(7'h50, 4'd0, 32'h0000_0010, 16'd5, 1'b0));
    send_word(start_word(7'h50, 4'd3, 32'h0000_0010, 16'd0, 1'b1));
  endtask

  // Writes: single address byte at field extremes, and an address length
  // above four that must clamp.
  task automatic test_writes();
    run_transfer(start_word(7'h7F, 4'd1, 32'hFFFF_FFFF, 16'd1, 1'b0), 0, 16);
    run_transfer(start_word(7'h00, 4'd15, 32'h1234_5678, 16'd2, 1'b0), 0, 16);
  endtask

  // Reads: single byte uses the single-receive command; two bytes the burst.
  task automatic test_reads();
    run_transfer(start_word(7'h2A, 4'd2, 32'h0000_ABCD, 16'd1, 1'b1), 0, 16);
    run_transfer(start_word(7'h55, 4'd1, 32'h0000_0000, 16'd2, 1'b1), 0, 16);
  endtask

  // Bus error in the address phase and in the finish phase.
  task automatic test_bus_errors();
    i2cs_pkg::in_word_t w;
    send_word(start_word(7'h11, 4'd3, 32'h00AB_CDEF, 16'd4, 1'b0));
    send_word(done_word(100));
    run_transfer(start_word(7'h12, 4'd1, 32'h0000_0001, 16'd2, 1'b1), 0, 2);
    w = done_word(100);
    send_word(w);
  endtask

  // A start aborts a long transfer in progress.
  task automatic test_abort();
    run_transfer(start_word(7'h33, 4'd4, 32'hDEAD_BEEF, 16'hFFFF, 1'b1), 0, 6);
    run_transfer(start_word(7'h34, 4'd2, 32'h0000_8001, 16'd1, 1'b0), 0, 16);
  endtask

  // Random transfers with noise: stray done words, bus errors, aborts.
  task automatic test_random_traffic(input int n_words);
    int target;
    target = words_sent + n_words;
    while (words_sent < target) begin
      if ($urandom_range(99) < 8) send_word(done_word(10));
      run_transfer(random_start(), 4,
                   ($urandom_range(99) < 10) ? $urandom_range(1, 10) : 80);
    end
  endtask

  // Sender pauses mid-stream until all results are back.
  task automatic test_drain_pause();
    test_random_traffic(50);
    wait_drained();
    test_random_traffic(50);
  endtask

  // Back-to-back words with both channels always ready.
  task automatic test_no_gaps();
    gaps_on = 1'b0;
    test_random_traffic(150);
    gaps_on = 1'b1;
  endtask

  initial begin
    int waited;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_word    = '0;
    gaps_on    = 1'b1;
    mismatches = 0;
    words_sent = 0;
    seq_phase      = i2cs_pkg::PH_IDLE;
    seq_addr_count = 0;
    seq_addr_pos   = 0;
    seq_data_pos   = '0;
    seq_total      = '0;
    seq_read       = 1'b0;
    seq_slave      = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_and_empty();
    test_writes();
    test_reads();
    test_bus_errors();
    test_abort();
    test_random_traffic(400);
    test_no_gaps();
    test_drain_pause();

    // let the pipe empty; two stages plus stall slack
    in_valid <= 1'b0;
    waited = 0;
    while (expected_steps.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (expected_steps.size() != 0) begin
      mismatches += expected_steps.size();
      $display("%0t ns: %0d result words expected, actual none", $time,
               expected_steps.size());
    end
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
